// ===== hdl/palette_color_mixer_macros.svh =====
// assertion macros shared by the palette colour mixer rtl
`ifndef PALETTE_COLOR_MIXER_MACROS_SVH
`define PALETTE_COLOR_MIXER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define PCM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication delayed by the n argument
`define PCM_ASSERT_DELAY(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== hdl/pcm_pkg.sv =====
// shared types and constants of the palette colour mixer
package pcm_pkg;

  localparam int PAL_DEPTH = 256;
  localparam int MAP_DEPTH = 32768;
  localparam int IDX_W     = 8;
  localparam int COL_W     = 15;
  localparam int ENTRY_W   = 16;
  localparam int RESULT_LATENCY = 7;

  localparam logic [7:0] RAW_MAX   = 8'h3F;
  localparam logic [4:0] CHAN_FULL = 5'd31;

  typedef enum logic [1:0] {
    REQ_PAL  = 2'd0,
    REQ_MAP  = 2'd1,
    REQ_MIX  = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  // additive and multiplicative mix of two palette entries
  typedef struct packed {
    logic             both_ok;
    logic             b_ok;
    logic             ovf;
    logic [4:0]       step;
    logic [COL_W-1:0] add_addr;
    logic [COL_W-1:0] mul_addr;
  } mix_calc_t;

  // brightened colour of one palette entry
  typedef struct packed {
    logic             ok;
    logic [COL_W-1:0] addr;
  } bright_t;

  // one pipeline stage: request, load payload and mix progress
  typedef struct packed {
    logic               valid;
    req_t               req;
    logic [IDX_W-1:0]   ia;
    logic [IDX_W-1:0]   ib;
    logic [ENTRY_W-1:0] pal_word;
    logic [COL_W-1:0]   map_addr;
    logic [IDX_W-1:0]   map_data;
    mix_calc_t          calc;
    logic [IDX_W-1:0]   fb;
    logic [IDX_W-1:0]   add_map;
    logic [IDX_W-1:0]   mul_map;
    bright_t            br;
  } stage_t;

endpackage

// ===== hdl/pcm_ram.sv =====
// generic single write port ram with registered read
module pcm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pcm_mix_calc.sv =====
// channel sums, overflow clamp and products of two palette entries
module pcm_mix_calc import pcm_pkg::*; (
  input  logic [ENTRY_W-1:0] entry_a,
  input  logic [ENTRY_W-1:0] entry_b,
  output mix_calc_t          calc
);

  logic [5:0] sr, sg, sb, mx, ex, cr, cg, cb;
  logic [9:0] pr, pg, pb;

  always_comb begin
    sr = {1'b0, entry_a[14:10]} + {1'b0, entry_b[14:10]};
    sg = {1'b0, entry_a[9:5]}   + {1'b0, entry_b[9:5]};
    sb = {1'b0, entry_a[4:0]}   + {1'b0, entry_b[4:0]};
    mx = sr;
    if (sg > mx) begin
      mx = sg;
    end
    if (sb > mx) begin
      mx = sb;
    end
    // excess over full scale, meaningful only on overflow
    ex = mx - {1'b0, CHAN_FULL};
    cr = (sr > ex) ? sr - ex : 6'd0;
    cg = (sg > ex) ? sg - ex : 6'd0;
    cb = (sb > ex) ? sb - ex : 6'd0;
    pr = {5'd0, entry_a[14:10]} * {5'd0, entry_b[14:10]};
    pg = {5'd0, entry_a[9:5]}   * {5'd0, entry_b[9:5]};
    pb = {5'd0, entry_a[4:0]}   * {5'd0, entry_b[4:0]};

    calc.both_ok  = entry_a[15] & entry_b[15];
    calc.b_ok     = entry_b[15];
    calc.ovf      = mx[5];
    calc.step     = ex[4:0];
    calc.add_addr = mx[5] ? {cr[4:0], cg[4:0], cb[4:0]} : {sr[4:0], sg[4:0], sb[4:0]};
    calc.mul_addr = {pr[9:5], pg[9:5], pb[9:5]};
  end

endmodule

// ===== hdl/pcm_brighten.sv =====
// lifts each channel of a palette entry toward white by step/128
module pcm_brighten import pcm_pkg::*; (
  input  logic [ENTRY_W-1:0] entry,
  input  logic [4:0]         step,
  output bright_t            res
);

  function automatic logic [4:0] lift(input logic [4:0] c, input logic [4:0] s);
    logic [4:0] inv;
    logic [9:0] p;
    inv = CHAN_FULL - c;
    p   = {5'd0, inv} * {5'd0, s};
    return c + {2'd0, p[9:7]};
  endfunction

  always_comb begin
    res.ok   = entry[15];
    res.addr = {lift(entry[14:10], step), lift(entry[9:5], step), lift(entry[4:0], step)};
  end

endmodule

// ===== hdl/palette_color_mixer.sv =====
// top level of the palette colour mixer: request pipeline and its memories
//
//   channel   handshake          fields
//   request   start, busy        req_type index_a index_b red_raw green_raw
//                                blue_raw map_address map_data
//   result    done (one cycle)   add_index mul_index
//
// a request is taken in any cycle (busy stays low); a mix request gives one
// result, loads give none. the result passes through the chain of registered
// memory reads: palette, inverse map, palette again for brightening, inverse
// map again, and then the output register.
// reset clears the stage valid bits and done; both memories are undefined
// until loaded. the receiver cannot stall, so nothing in the pipeline waits.
`include "palette_color_mixer_macros.svh"

module palette_color_mixer import pcm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       req_type,
  input  logic [IDX_W-1:0] index_a,
  input  logic [IDX_W-1:0] index_b,
  input  logic [7:0]       red_raw,
  input  logic [7:0]       green_raw,
  input  logic [7:0]       blue_raw,
  input  logic [COL_W-1:0] map_address,
  input  logic [IDX_W-1:0] map_data,
  output logic             done,
  output logic [IDX_W-1:0] add_index,
  output logic [IDX_W-1:0] mul_index
);

  // stage registers, one per pipeline stage after acceptance
  stage_t pipe      [1:6];
  stage_t pipe_next [1:6];

  logic               pal_ok;
  logic [ENTRY_W-1:0] pal_word;
  logic [ENTRY_W-1:0] pa_rdata, pb_rdata, pbr_rdata;
  logic [IDX_W-1:0]   madd_rdata, mmul_rdata, mbr_rdata;
  mix_calc_t          calc;
  bright_t            bright;
  logic               pal_we0, map_we2, pal_we3, map_we5;
  logic [IDX_W-1:0]   add_sel;

  // fully pipelined, never refuses a request
  assign busy = 1'b0;

  // palette entry word: halve each channel, black and invalid if any is over 63
  assign pal_ok   = (red_raw <= RAW_MAX) && (green_raw <= RAW_MAX) && (blue_raw <= RAW_MAX);
  assign pal_word = pal_ok ? {1'b1, red_raw[5:1], green_raw[5:1], blue_raw[5:1]}
                           : '0;

  // each memory copy is written as the load passes the stage where it is read,
  // so every query sees exactly the loads taken before it
  assign pal_we0 = start && (req_type == REQ_PAL);
  assign map_we2 = pipe[2].valid && (pipe[2].req == REQ_MAP);
  assign pal_we3 = pipe[3].valid && (pipe[3].req == REQ_PAL);
  assign map_we5 = pipe[5].valid && (pipe[5].req == REQ_MAP);

  // stage 0: palette operand reads
  pcm_ram #(.Width(ENTRY_W), .Depth(PAL_DEPTH)) u_pal_a (
    .clk   (clk),
    .we    (pal_we0),
    .waddr (index_a),
    .wdata (pal_word),
    .raddr (index_a),
    .rdata (pa_rdata)
  );

  pcm_ram #(.Width(ENTRY_W), .Depth(PAL_DEPTH)) u_pal_b (
    .clk   (clk),
    .we    (pal_we0),
    .waddr (index_a),
    .wdata (pal_word),
    .raddr (index_b),
    .rdata (pb_rdata)
  );

  // stage 1: sums, clamp and products
  pcm_mix_calc u_mix (
    .entry_a (pa_rdata),
    .entry_b (pb_rdata),
    .calc    (calc)
  );

  // stage 2: inverse map reads for both mixes
  pcm_ram #(.Width(IDX_W), .Depth(MAP_DEPTH)) u_map_add (
    .clk   (clk),
    .we    (map_we2),
    .waddr (pipe[2].map_addr),
    .wdata (pipe[2].map_data),
    .raddr (pipe[2].calc.add_addr),
    .rdata (madd_rdata)
  );

  pcm_ram #(.Width(IDX_W), .Depth(MAP_DEPTH)) u_map_mul (
    .clk   (clk),
    .we    (map_we2),
    .waddr (pipe[2].map_addr),
    .wdata (pipe[2].map_data),
    .raddr (pipe[2].calc.mul_addr),
    .rdata (mmul_rdata)
  );

  // stage 3: palette read of the clamped additive colour, straight off the map read
  pcm_ram #(.Width(ENTRY_W), .Depth(PAL_DEPTH)) u_pal_br (
    .clk   (clk),
    .we    (pal_we3),
    .waddr (pipe[3].ia),
    .wdata (pipe[3].pal_word),
    .raddr (madd_rdata),
    .rdata (pbr_rdata)
  );

  // stage 4: brightening by the excess
  pcm_brighten u_bright (
    .entry (pbr_rdata),
    .step  (pipe[4].calc.step),
    .res   (bright)
  );

  // stage 5: inverse map read of the brightened colour
  pcm_ram #(.Width(IDX_W), .Depth(MAP_DEPTH)) u_map_br (
    .clk   (clk),
    .we    (map_we5),
    .waddr (pipe[5].map_addr),
    .wdata (pipe[5].map_data),
    .raddr (pipe[5].br.addr),
    .rdata (mbr_rdata)
  );

  always_comb begin
    pipe_next[1]          = '0;
    pipe_next[1].valid    = start;
    pipe_next[1].req      = req_t'(req_type);
    pipe_next[1].ia       = index_a;
    pipe_next[1].ib       = index_b;
    pipe_next[1].pal_word = pal_word;
    pipe_next[1].map_addr = map_address;
    pipe_next[1].map_data = map_data;

    pipe_next[2]      = pipe[1];
    pipe_next[2].calc = calc;
    // invalid operand: fall back to b when b is valid, else a
    pipe_next[2].fb   = calc.b_ok ? pipe[1].ib : pipe[1].ia;

    pipe_next[3] = pipe[2];

    // map read data belongs to the request in stage 3
    pipe_next[4]         = pipe[3];
    pipe_next[4].add_map = madd_rdata;
    pipe_next[4].mul_map = mmul_rdata;

    pipe_next[5]    = pipe[4];
    pipe_next[5].br = bright;

    pipe_next[6] = pipe[5];
  end

  // final additive index: fallback, direct map, or brightened (0 if entry invalid)
  always_comb begin
    if (!pipe[6].calc.both_ok) begin
      add_sel = pipe[6].fb;
    end else if (!pipe[6].calc.ovf) begin
      add_sel = pipe[6].add_map;
    end else if (pipe[6].br.ok) begin
      add_sel = mbr_rdata;
    end else begin
      add_sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= 6; k++) begin
      if (rst) begin
        pipe[k].valid <= 1'b0;
      end else begin
        pipe[k] <= pipe_next[k];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pipe[6].valid && (pipe[6].req == REQ_MIX);
    end
    add_index <= add_sel;
    mul_index <= pipe[6].calc.both_ok ? pipe[6].mul_map : pipe[6].fb;
  end

  `PCM_ASSERT_DELAY(a_mix_gives_result, start && !busy && (req_type == REQ_MIX),
                    RESULT_LATENCY, done, "mix request lost its result")
  `PCM_ASSERT_DELAY(a_load_silent, start && !busy && (req_type != REQ_MIX),
                    RESULT_LATENCY, !done, "result invented for a non-mix request")
  `PCM_ASSERT_IMPL(a_split_needs_valid, done && (add_index != mul_index),
                   $past(pipe[6].calc.both_ok), "fallback result gave two indices")
  `PCM_ASSERT_IMPL(a_step_nonzero, pipe[2].valid && pipe[2].calc.ovf,
                   pipe[2].calc.step != 5'd0, "overflow with zero excess")

endmodule
